// ===== sv/utf8d_pkg.sv =====
package utf8d_pkg;

  localparam int unsigned CpW     = 31;
  localparam int unsigned LenW    = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_CODE_POINT    = 1'd0,
    REG_REJECT_SURROGATES = 1'd1
  } cfg_reg_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEAD  = 3'd1,
    ST_BAD_CONT  = 3'd2,
    ST_INVALID   = 3'd3,
    ST_EARLY_END = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CLS_ASCII = 2'd0,
    CLS_LEAD  = 2'd1,
    CLS_CONT  = 2'd2,
    CLS_BAD   = 2'd3
  } byte_cls_e;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    byte_cls_e       cls;
    logic [LenW-1:0] len;  // sequence length announced by a lead byte
    logic [CpW-1:0]  val;  // value bits, already placed for a lead byte
    logic            eos;
  } q_entry_t;

endpackage

// ===== sv/utf8_stream_decoder.sv =====
// Path: an accepted byte is stored in the queue, then decoded from its head into the output register.
// Throughput: one byte per cycle unless stalled; the back-end sequence register takes one byte
// each cycle, and up to four classified bytes wait in the queue while the output is stalled.
// Reset: asynchronous, active low; the decoder returns to idle, the queue and output empty,
// max_code_point to 0x7FFFFFFF and reject_surrogates to 1.
module utf8_stream_decoder
  import utf8d_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CpW-1:0]       cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ByteW-1:0]     s_axis_tdata,   // in_byte
  input  logic                 s_axis_tlast,   // end_of_stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,   // code_point, seq_length, zero fill
  output logic [StatusW-1:0]   m_axis_tuser    // status
);

  q_entry_t        front_entry;
  q_entry_t        q_entry;
  logic            q_valid;
  logic            q_ready;
  logic [CpW-1:0]  res_cp;
  logic [LenW-1:0] res_len;

  utf8d_front u_front (
    .byte_i  (s_axis_tdata),
    .eos_i   (s_axis_tlast),
    .entry_o (front_entry)
  );

  utf8d_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_data_i  (front_entry),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_entry)
  );

  utf8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_entry),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_cp_o     (res_cp),
    .res_len_o    (res_len),
    .res_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = {{(OutDataW - CpW - LenW){1'b0}}, res_len, res_cp};

endmodule

// ===== sv/utf8d_front.sv =====
module utf8d_front
  import utf8d_pkg::*;
(
  input  logic [ByteW-1:0] byte_i,
  input  logic             eos_i,
  output q_entry_t         entry_o
);

  always_comb begin
    entry_o.eos = eos_i;
    entry_o.len = 3'd1;
    entry_o.val = '0;
    entry_o.cls = CLS_BAD;
    if (byte_i[7] == 1'b0) begin
      entry_o.cls = CLS_ASCII;
      entry_o.val = {{(CpW - ByteW){1'b0}}, byte_i};
    end else if (byte_i[7:6] == 2'b10) begin
      entry_o.cls = CLS_CONT;
      entry_o.val = {{(CpW - 6){1'b0}}, byte_i[5:0]};
    end else if (byte_i[7:5] == 3'b110) begin
      entry_o.cls = CLS_LEAD;
      entry_o.len = 3'd2;
      entry_o.val = {{(CpW - 11){1'b0}}, byte_i[4:0], 6'd0};
    end else if (byte_i[7:4] == 4'b1110) begin
      entry_o.cls = CLS_LEAD;
      entry_o.len = 3'd3;
      entry_o.val = {{(CpW - 16){1'b0}}, byte_i[3:0], 12'd0};
    end else if (byte_i[7:3] == 5'b11110) begin
      entry_o.cls = CLS_LEAD;
      entry_o.len = 3'd4;
      entry_o.val = {{(CpW - 21){1'b0}}, byte_i[2:0], 18'd0};
    end else if (byte_i[7:2] == 6'b111110) begin
      entry_o.cls = CLS_LEAD;
      entry_o.len = 3'd5;
      entry_o.val = {{(CpW - 26){1'b0}}, byte_i[1:0], 24'd0};
    end else if (byte_i[7:1] == 7'b1111110) begin
      entry_o.cls = CLS_LEAD;
      entry_o.len = 3'd6;
      entry_o.val = {byte_i[0], 30'd0};
    end
  end

endmodule

// ===== sv/utf8d_queue.sv =====
module utf8d_queue
  import utf8d_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  q_entry_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output q_entry_t pop_data_o
);

  q_entry_t           mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   cnt_q;
  logic               push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/utf8d_back.sv =====
module utf8d_back
  import utf8d_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CpW-1:0]      cfg_wdata_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  q_entry_t            item_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic [CpW-1:0]      res_cp_o,
  output logic [LenW-1:0]     res_len_o,
  output logic [StatusW-1:0]  res_status_o
);

  logic [CpW-1:0]   max_cp_q;
  logic             rej_surr_q;
  logic [CpW-1:0]   part_q, part_d;
  logic [LenW-1:0]  rem_q, rem_d, len_q, len_d;
  logic             out_valid_q;
  logic [CpW-1:0]   out_cp_q;
  logic [LenW-1:0]  out_len_q;
  status_e          out_st_q;
  logic             pop;
  logic             res_v;
  logic [CpW-1:0]   res_cp;
  logic [LenW-1:0]  res_len;
  status_e          res_st;
  logic [LenW-1:0]  got;
  logic [LenW-1:0]  rem_next;
  logic [CpW-1:0]   full_val;
  logic [CpW-1:0]   shifted;

  function automatic logic [CpW-1:0] overlong_limit(input logic [LenW-1:0] len);
    logic [CpW-1:0] lim;
    case (len)
      3'd2:    lim = 31'h7F;
      3'd3:    lim = 31'h7FF;
      3'd4:    lim = 31'hFFFF;
      3'd5:    lim = 31'h1FFFFF;
      3'd6:    lim = 31'h3FFFFFF;
      default: lim = '0;
    endcase
    return lim;
  endfunction

  // Only one item is in the back at a time, and it yields at most one result,
  // so the output register decides whether the next item may be taken.
  assign pop          = item_valid_i && (!out_valid_q || res_ready_i);
  assign item_ready_o = !out_valid_q || res_ready_i;

  assign got      = len_q - rem_q + 3'd1;
  assign rem_next = rem_q - 3'd1;
  assign full_val = part_q | item_i.val;

  always_comb begin
    case (rem_next)
      3'd1:    shifted = item_i.val << 6;
      3'd2:    shifted = item_i.val << 12;
      3'd3:    shifted = item_i.val << 18;
      3'd4:    shifted = item_i.val << 24;
      default: shifted = item_i.val;
    endcase
  end

  always_comb begin
    part_d  = part_q;
    rem_d   = rem_q;
    len_d   = len_q;
    res_v   = 1'b0;
    res_cp  = '0;
    res_len = 3'd1;
    res_st  = ST_OK;
    if (rem_q == '0) begin
      case (item_i.cls)
        CLS_ASCII: begin
          res_v = 1'b1;
          if (item_i.val > max_cp_q) begin
            res_st = ST_INVALID;
          end else begin
            res_cp = item_i.val;
          end
        end
        CLS_LEAD: begin
          if (item_i.eos) begin
            res_v  = 1'b1;
            res_st = ST_EARLY_END;
          end else begin
            part_d = item_i.val;
            len_d  = item_i.len;
            rem_d  = item_i.len - 3'd1;
          end
        end
        default: begin
          res_v  = 1'b1;
          res_st = ST_BAD_LEAD;
        end
      endcase
    end else if (item_i.eos && rem_q > 3'd1) begin
      res_v   = 1'b1;
      res_len = got;
      res_st  = ST_EARLY_END;
      part_d  = '0;
      rem_d   = '0;
      len_d   = '0;
    end else if (item_i.cls != CLS_CONT) begin
      res_v   = 1'b1;
      res_len = got;
      res_st  = ST_BAD_CONT;
      part_d  = '0;
      rem_d   = '0;
      len_d   = '0;
    end else if (rem_q == 3'd1) begin
      res_v   = 1'b1;
      res_len = len_q;
      part_d  = '0;
      rem_d   = '0;
      len_d   = '0;
      if (full_val <= overlong_limit(len_q) || full_val > max_cp_q ||
          (rej_surr_q && full_val >= 31'hD800 && full_val <= 31'hDFFF)) begin
        res_st = ST_INVALID;
      end else begin
        res_cp = full_val;
      end
    end else begin
      rem_d  = rem_next;
      part_d = part_q | shifted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cp_q   <= '1;
      rej_surr_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MAX_CODE_POINT:    max_cp_q   <= cfg_wdata_i;
        REG_REJECT_SURROGATES: rej_surr_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q      <= '0;
      rem_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        part_q <= part_d;
        rem_q  <= rem_d;
        len_q  <= len_d;
      end
      if (pop && res_v) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && res_v) begin
      out_cp_q  <= res_cp;
      out_len_q <= res_len;
      out_st_q  <= res_st;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_cp_o     = out_cp_q;
  assign res_len_o    = out_len_q;
  assign res_status_o = out_st_q;

endmodule

// ===== sv/utf8d_checker.sv =====
module utf8d_checker
  import utf8d_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [StatusW-1:0]  m_axis_tuser
);

  logic [CpW-1:0]  cp;
  logic [LenW-1:0] len;

  assign cp  = m_axis_tdata[CpW-1:0];
  assign len = m_axis_tdata[CpW+LenW-1:CpW];

  // A stalled result must not change.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> cp == '0)
    else $error("error result carries a nonzero code point");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> len != 3'd0 && len != 3'd7)
    else $error("sequence length out of range");

  // A good multi-byte result is never overlong, and a good single byte is ASCII.
  a_ok_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_OK |->
      ((len == 3'd1 && cp <= 31'h7F) || (len != 3'd1 && cp > 31'h7F)))
    else $error("good result has a value that does not fit its length");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/utf8_stream_decoder_test.sv =====
module utf8_stream_decoder_test
  import utf8d_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned PhaseBytes    = 225;
  localparam int unsigned HoldCycles    = 400;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             eos;
  } stream_byte_t;

  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
    status_e         status;
  } char_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CpW-1:0]      cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]  m_axis_tuser;

  utf8_stream_decoder i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  always #5 clk_i = ~clk_i;

  stream_byte_t pending_bytes[$];
  char_result_t expected_chars[$];
  stream_byte_t tx_byte;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          rx_hold_asks = 0;
  int          rx_hold_seen = 0;
  int          rx_hold_left = 0;
  int          phase_bytes = 0;
  int          mismatch_cnt = 0;
  int unsigned stall_cycles = 0;
  logic        in_taken = 1'b0;

  // Decoder state and register copies as seen by the checker.
  logic [CpW-1:0] lim_cp   = 31'h7FFF_FFFF;
  logic           rej_surr = 1'b1;
  logic [CpW-1:0] dec_partial = '0;
  int             dec_owed = 0;
  int             dec_len = 0;

  function automatic bit cp_allowed(logic [CpW-1:0] v);
    if (v > lim_cp) return 1'b0;
    if (rej_surr && v >= 31'hD800 && v <= 31'hDFFF) return 1'b0;
    return 1'b1;
  endfunction

  task automatic expect_char(logic [CpW-1:0] cp, int len, status_e st);
    char_result_t r;
    r.cp = cp;
    r.len = 3'(len);
    r.status = st;
    expected_chars.push_back(r);
  endtask

  task automatic decode_byte(logic [ByteW-1:0] b, logic eos);
    int             n;
    int             got;
    logic [CpW-1:0] v;
    logic [CpW-1:0] overlong_max;
    if (dec_owed == 0) begin
      if (!b[7]) begin
        if (cp_allowed({23'd0, b})) expect_char({23'd0, b}, 1, ST_OK);
        else expect_char('0, 1, ST_INVALID);
        return;
      end
      casez (b)
        8'b110?????: begin n = 2; v = 31'(b[4:0]) << 6; end
        8'b1110????: begin n = 3; v = 31'(b[3:0]) << 12; end
        8'b11110???: begin n = 4; v = 31'(b[2:0]) << 18; end
        8'b111110??: begin n = 5; v = 31'(b[1:0]) << 24; end
        8'b1111110?: begin n = 6; v = 31'(b[0]) << 30; end
        default: begin
          expect_char('0, 1, ST_BAD_LEAD);
          return;
        end
      endcase
      if (eos) begin
        expect_char('0, 1, ST_EARLY_END);
        return;
      end
      dec_partial = v;
      dec_len = n;
      dec_owed = n - 1;
      return;
    end
    got = dec_len - dec_owed + 1;
    if (eos && dec_owed > 1) begin
      dec_owed = 0;
      dec_partial = '0;
      expect_char('0, got, ST_EARLY_END);
    end else if (b[7:6] != 2'b10) begin
      dec_owed = 0;
      dec_partial = '0;
      expect_char('0, got, ST_BAD_CONT);
    end else begin
      dec_owed--;
      dec_partial = dec_partial | (31'(b[5:0]) << (6 * dec_owed));
      if (dec_owed == 0) begin
        v = dec_partial;
        n = dec_len;
        dec_partial = '0;
        dec_len = 0;
        case (n)
          2:       overlong_max = 31'h7F;
          3:       overlong_max = 31'h7FF;
          4:       overlong_max = 31'hFFFF;
          5:       overlong_max = 31'h1F_FFFF;
          default: overlong_max = 31'h3FF_FFFF;
        endcase
        if (v <= overlong_max || !cp_allowed(v)) expect_char('0, n, ST_INVALID);
        else expect_char(v, n, ST_OK);
      end
    end
  endtask

  task automatic note_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_char(logic [CpW-1:0] cp, logic [LenW-1:0] len, logic [StatusW-1:0] st);
    char_result_t want;
    if (expected_chars.size() == 0) begin
      note_mismatch($sformatf("result with nothing expected: cp=%h len=%0d status=%0d",
                              cp, len, st));
    end else begin
      want = expected_chars.pop_front();
      if (cp !== want.cp || len !== want.len || st !== want.status)
        note_mismatch($sformatf("expected cp=%h len=%0d status=%0d, got cp=%h len=%0d status=%0d",
                                want.cp, want.len, want.status, cp, len, st));
    end
  endtask

  // Monitor: predicts on every input transaction and checks every output transaction.
  always @(posedge clk_i) begin
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        check_char(m_axis_tdata[CpW-1:0], m_axis_tdata[CpW +: LenW], m_axis_tuser);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Driver: a byte stays on the bus until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        tx_byte = pending_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tx_byte.data;
        s_axis_tlast  <= tx_byte.eos;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_asks != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_asks;
      rx_hold_left <= HoldCycles;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic add_byte(logic [ByteW-1:0] b, logic eos);
    stream_byte_t item;
    item.data = b;
    item.eos = eos;
    pending_bytes.push_back(item);
    phase_bytes++;
  endtask

  // Mostly well-formed sequences with random content, plus cut or damaged ones and noise.
  task automatic add_random_group();
    int             kind;
    int             n;
    int             bits;
    int             last;
    logic [CpW-1:0] v;
    logic [7:0]     enc [6];
    kind = $urandom_range(99);
    if (kind >= 80) begin
      add_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
      return;
    end
    n = $urandom_range(1, 6);
    bits = (n == 1) ? 7 : 5 * n + 1;
    case ($urandom_range(7))
      0:       v = 31'hD7FF + 31'($urandom_range(2049));
      1:       v = lim_cp + 31'($urandom_range(2)) - 31'd1;
      2:       v = (31'd1 << (5 * n - 3)) - 31'd1 + 31'($urandom_range(1));
      default: v = 31'($urandom);
    endcase
    v &= (31'd1 << bits) - 31'd1;
    if (n == 1) begin
      enc[0] = {1'b0, v[6:0]};
    end else begin
      enc[0] = (8'hFF << (8 - n)) | 8'(v >> (6 * (n - 1)));
      for (int i = 1; i < n; i++) enc[i] = 8'h80 | 8'((v >> (6 * (n - 1 - i))) & 31'h3F);
    end
    last = n - 1;
    if (kind >= 60 && n > 1) begin
      if ($urandom_range(1)) last = $urandom_range(n - 2);
      else enc[$urandom_range(1, n - 1)] = 8'($urandom_range(255));
    end
    for (int i = 0; i <= last; i++) add_byte(enc[i], $urandom_range(39) == 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CpW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MAX_CODE_POINT) lim_cp = val;
    else rej_surr = val[0];
  endtask

  // Lets the stream drain, closes any open sequence and waits for the decoder to go quiet.
  task automatic finish_phase();
    do begin
      @(posedge clk_i);
      while (pending_bytes.size() != 0 || s_axis_tvalid) @(posedge clk_i);
      if (dec_owed != 0) add_byte(8'h41, 1'b0);
    end while (pending_bytes.size() != 0);
    while (expected_chars.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(REG_MAX_CODE_POINT, 31'h7FFF_FFFF);
    write_reg(REG_REJECT_SURROGATES, 31'd1);
    tx_idle_pct = 22;
    rx_idle_pct = 51;

    add_byte(8'h00, 1'b1);                    // end flag on a plain byte changes nothing
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b0);                    // stray continuation as a lead
    add_byte(8'hFF, 1'b0);
    add_byte(8'hC2, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_byte(8'hC1, 1'b0);                    // overlong two-byte form
    add_byte(8'hBF, 1'b0);
    add_byte(8'hED, 1'b0);                    // surrogate
    add_byte(8'hA0, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFD, 1'b0);                    // largest six-byte value
    for (int i = 0; i < 5; i++) add_byte(8'hBF, 1'b0);
    add_byte(8'hE2, 1'b0);                    // broken by a plain byte, which is dropped
    add_byte(8'h41, 1'b0);
    add_byte(8'hF0, 1'b0);                    // stream ends two bytes in
    add_byte(8'h90, 1'b1);
    add_byte(8'hF8, 1'b1);                    // stream ends on the lead byte
    add_byte(8'hDF, 1'b0);                    // end flag on the final byte completes normally
    add_byte(8'hBF, 1'b1);
    finish_phase();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_MAX_CODE_POINT, 31'h7FFF_FFFF);
          write_reg(REG_REJECT_SURROGATES, 31'd0);
        end
        1: begin
          write_reg(REG_MAX_CODE_POINT, 31'h7F);
          write_reg(REG_REJECT_SURROGATES, 31'd1);
        end
        2: write_reg(REG_MAX_CODE_POINT, 31'h10_FFFF);
        3: begin
          write_reg(REG_MAX_CODE_POINT, 31'hFFFF);
          write_reg(REG_REJECT_SURROGATES, 31'd0);
        end
        4: begin
          write_reg(REG_MAX_CODE_POINT, 31'h7FF);
          write_reg(REG_REJECT_SURROGATES, 31'd1);
        end
        default: write_reg(REG_MAX_CODE_POINT, 31'h7FFF_FFFF);
      endcase
      tx_idle_pct = (ph < 2) ? 22 : (ph < 4) ? 51 : 0;
      rx_idle_pct = (ph < 2) ? 51 : (ph < 4) ? 22 : 0;
      // With no idling on the sender, a long receiver stall backs the block up to its input.
      if (ph == 4) rx_hold_asks++;
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) add_random_group();
      finish_phase();
    end

    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0 && expected_chars.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
